// ===== rtl/rpap_pkg.sv =====
package rpap_pkg;

    localparam int ANGLE_STEPS  = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STEPS = (ANGLE_STEPS < ATAN_ENTRIES) ? ANGLE_STEPS : ATAN_ENTRIES;

    // pipeline stage indexes after the cordic chain
    localparam int ST_TRIG = CORDIC_STEPS + 1;
    localparam int ST_MUL  = CORDIC_STEPS + 2;
    localparam int ST_SUM  = CORDIC_STEPS + 3;
    localparam int ST_OUT  = CORDIC_STEPS + 4;

    localparam int IN_TDATA_W  = 216;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 1;

    localparam int FW = 35;  // unfolded angle, Q4.30
    localparam int ZW = 33;  // folded angle residue
    localparam int CW = 34;  // cordic x / y
    localparam int TW = 32;  // clamped cos / sin
    localparam int DW = 33;  // point minus pivot
    localparam int PW = 65;  // one product
    localparam int SW = 66;  // sum of two products
    localparam int RW = 37;  // shifted sum plus pivot

    localparam logic signed [FW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [FW-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [FW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sh26DD3B6A;
    localparam logic signed [CW-1:0] ONE_Q30     = 34'sh40000000;
    localparam logic signed [SW-1:0] HALF_Q30    = 66'sh20000000;
    localparam logic signed [RW-1:0] COORD_MAX   = 37'sh007FFFFFFF;
    localparam logic signed [RW-1:0] COORD_MIN   = -37'sh0080000000;

    typedef enum logic [1:0] {
        AX_X   = 2'd0,
        AX_Y   = 2'd1,
        AX_Z   = 2'd2,
        AX_BAD = 2'd3
    } t_axis;

    typedef logic signed [31:0]   t_coord;
    typedef logic signed [DW-1:0] t_diff;

    typedef struct packed {
        t_coord px;
        t_coord py;
        t_coord pz;
        t_coord qx;
        t_coord qy;
        t_coord qz;
        t_diff  dx;
        t_diff  dy;
        t_diff  dz;
        t_axis  axis;
        logic   neg;
    } t_side;

    // atan(2^-i) in Q30, truncated
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic t_coord sat_coord(input logic signed [RW-1:0] v);
        t_coord r;
        if (v > COORD_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < COORD_MIN) begin
            r = -32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/rotate_point_about_pivot.sv =====
// Throughput: one transaction per cycle while s_axis_tready is high; each CORDIC
// iteration has its own stage, followed by clamp, multiply, sum and saturate stages.
// A one-entry skid register behind the last stage takes the result in the cycle a
// stall begins; the whole pipe then holds, with s_axis_tready low, until it drains.
// Reset (synchronous, active low) clears valid bits only.
module rotate_point_about_pivot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x, point_y, point_z, pivot_x, pivot_y, pivot_z, angle, 4 zero bits
    input  logic [rpap_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // axis_select
    input  logic [rpap_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [rpap_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // axis_error
    output logic [rpap_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import rpap_pkg::*;

    logic                   w_en;
    logic [0:ST_OUT]        r_vld;
    t_side                  r_side [0:ST_OUT];

    logic signed [CW-1:0]   r_x [0:CORDIC_STEPS];
    logic signed [CW-1:0]   r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0]   r_z [0:CORDIC_STEPS];

    logic signed [TW-1:0]   r_c;
    logic signed [TW-1:0]   r_s;
    t_diff                  r_a;
    t_diff                  r_b;
    logic signed [PW-1:0]   r_m_ca;
    logic signed [PW-1:0]   r_m_sb;
    logic signed [PW-1:0]   r_m_sa;
    logic signed [PW-1:0]   r_m_cb;
    logic signed [SW-1:0]   r_u;
    logic signed [SW-1:0]   r_v;

    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_err;
    logic                   r_skid_vld;
    logic [OUT_TDATA_W-1:0] r_skid_data;
    logic                   r_skid_err;

    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    // ---------------- stage 0: angle fold, differences ----------------
    t_coord                 w_px, w_py, w_pz, w_qx, w_qy, w_qz;
    logic [19:0]            w_ang;
    logic signed [FW-1:0]   w_za, w_zb, w_zc;
    logic                   w_neg;
    t_side                  w_side0;

    assign w_px  = s_axis_tdata[31:0];
    assign w_py  = s_axis_tdata[63:32];
    assign w_pz  = s_axis_tdata[95:64];
    assign w_qx  = s_axis_tdata[127:96];
    assign w_qy  = s_axis_tdata[159:128];
    assign w_qz  = s_axis_tdata[191:160];
    assign w_ang = s_axis_tdata[211:192];

    always_comb begin
        w_za = {w_ang[19], w_ang, 14'b0};
        if (w_za > PI_Q30) begin
            w_zb = w_za - TWO_PI_Q30;
        end else if (w_za < -PI_Q30) begin
            w_zb = w_za + TWO_PI_Q30;
        end else begin
            w_zb = w_za;
        end
        w_neg = 1'b0;
        if (w_zb > HALF_PI_Q30) begin
            w_zc  = w_zb - PI_Q30;
            w_neg = 1'b1;
        end else if (w_zb < -HALF_PI_Q30) begin
            w_zc  = w_zb + PI_Q30;
            w_neg = 1'b1;
        end else begin
            w_zc = w_zb;
        end
        w_side0.px   = w_px;
        w_side0.py   = w_py;
        w_side0.pz   = w_pz;
        w_side0.qx   = w_qx;
        w_side0.qy   = w_qy;
        w_side0.qz   = w_qz;
        w_side0.dx   = DW'(w_px) - DW'(w_qx);
        w_side0.dy   = DW'(w_py) - DW'(w_qy);
        w_side0.dz   = DW'(w_pz) - DW'(w_qz);
        w_side0.axis = t_axis'(s_axis_tuser[1:0]);
        w_side0.neg  = w_neg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side0;
            r_x[0]    <= GAIN_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= w_zc[ZW-1:0];
        end
    end

    // ---------------- CORDIC, one iteration per stage ----------------
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CW-1:0] w_sx;
        logic signed [CW-1:0] w_sy;
        logic signed [ZW-1:0] w_at;

        assign w_sx = r_x[i] >>> i;
        assign w_sy = r_y[i] >>> i;
        assign w_at = ZW'(atan_q30(i));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side[i+1] <= r_side[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - w_sy;
                    r_y[i+1] <= r_y[i] + w_sx;
                    r_z[i+1] <= r_z[i] - w_at;
                end else begin
                    r_x[i+1] <= r_x[i] + w_sy;
                    r_y[i+1] <= r_y[i] - w_sx;
                    r_z[i+1] <= r_z[i] + w_at;
                end
            end
        end
    end

    // ---------------- clamp cos / sin, pick operands ----------------
    t_side                  w_st;
    logic signed [CW-1:0]   w_xn, w_yn;
    logic signed [TW-1:0]   w_c, w_s, w_se;
    t_diff                  w_a, w_b;

    assign w_st = r_side[CORDIC_STEPS];

    always_comb begin
        w_xn = w_st.neg ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
        w_yn = w_st.neg ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        if (w_xn > ONE_Q30) begin
            w_c = TW'(ONE_Q30);
        end else if (w_xn < -ONE_Q30) begin
            w_c = TW'(-ONE_Q30);
        end else begin
            w_c = w_xn[TW-1:0];
        end
        if (w_yn > ONE_Q30) begin
            w_s = TW'(ONE_Q30);
        end else if (w_yn < -ONE_Q30) begin
            w_s = TW'(-ONE_Q30);
        end else begin
            w_s = w_yn[TW-1:0];
        end
        // rotation about y runs the other way round in the (x, z) plane
        w_se = (w_st.axis == AX_Y) ? -w_s : w_s;
        case (w_st.axis)
            AX_X: begin
                w_a = w_st.dy;
                w_b = w_st.dz;
            end
            AX_Y: begin
                w_a = w_st.dx;
                w_b = w_st.dz;
            end
            default: begin
                w_a = w_st.dx;
                w_b = w_st.dy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[ST_TRIG] <= w_st;
            r_c             <= w_c;
            r_s             <= w_se;
            r_a             <= w_a;
            r_b             <= w_b;
        end
    end

    // ---------------- products ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[ST_MUL] <= r_side[ST_TRIG];
            r_m_ca         <= PW'(r_c) * PW'(r_a);
            r_m_sb         <= PW'(r_s) * PW'(r_b);
            r_m_sa         <= PW'(r_s) * PW'(r_a);
            r_m_cb         <= PW'(r_c) * PW'(r_b);
        end
    end

    // ---------------- sums with rounding offset ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[ST_SUM] <= r_side[ST_MUL];
            r_u            <= SW'(r_m_ca) - SW'(r_m_sb) + HALF_Q30;
            r_v            <= SW'(r_m_sa) + SW'(r_m_cb) + HALF_Q30;
        end
    end

    // ---------------- shift, add pivot, saturate, place ----------------
    t_side                  w_so;
    logic signed [SW-1:0]   w_us, w_vs;
    logic signed [RW-1:0]   w_ur, w_vr;
    t_coord                 w_uq, w_vq, w_usat, w_vsat, w_rx, w_ry, w_rz;

    assign w_so = r_side[ST_SUM];

    always_comb begin
        w_uq   = (w_so.axis == AX_X) ? w_so.qy : w_so.qx;
        w_vq   = (w_so.axis == AX_Z) ? w_so.qy : w_so.qz;
        w_us   = r_u >>> 30;
        w_vs   = r_v >>> 30;
        w_ur   = RW'(w_us) + RW'(w_uq);
        w_vr   = RW'(w_vs) + RW'(w_vq);
        w_usat = sat_coord(w_ur);
        w_vsat = sat_coord(w_vr);
        case (w_so.axis)
            AX_X: begin
                w_rx = w_so.px;
                w_ry = w_usat;
                w_rz = w_vsat;
            end
            AX_Y: begin
                w_rx = w_usat;
                w_ry = w_so.py;
                w_rz = w_vsat;
            end
            AX_Z: begin
                w_rx = w_usat;
                w_ry = w_vsat;
                w_rz = w_so.pz;
            end
            default: begin
                w_rx = w_so.px;
                w_ry = w_so.py;
                w_rz = w_so.pz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[ST_OUT] <= w_so;
            r_out_data     <= {w_rz, w_ry, w_rx};
            r_out_err      <= (w_so.axis == AX_BAD);
        end
    end

    // ---------------- valid bits and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {s_axis_tvalid, r_vld[0:ST_OUT-1]};
            end
            if (r_skid_vld) begin
                if (m_axis_tready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (r_vld[ST_OUT] && !m_axis_tready) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_data <= r_out_data;
            r_skid_err  <= r_out_err;
        end
    end

    assign m_axis_tvalid = r_skid_vld || r_vld[ST_OUT];
    assign m_axis_tdata  = r_skid_vld ? r_skid_data : r_out_data;
    assign m_axis_tuser  = r_skid_vld ? r_skid_err : r_out_err;

    // ---------------- assertions ----------------
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (FW'(r_z[0]) <= HALF_PI_Q30) && (FW'(r_z[0]) >= -HALF_PI_Q30))
        else $error("folded angle outside half pi");

    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_OUT] && !m_axis_tready && !r_skid_vld |=> r_skid_vld)
        else $error("stalled result not captured in skid");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && !m_axis_tready |=> r_skid_vld && $stable(r_skid_data))
        else $error("skid entry lost before transaction");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && r_vld[ST_OUT] |=> $stable(r_out_data) || !r_skid_vld)
        else $error("last stage overwritten while skid full");

endmodule

// ===== test/rotate_point_about_pivot_tb.sv =====
module rotate_point_about_pivot_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpap_pkg::*;

    localparam longint ROT_PI      = 64'sd3373259426;
    localparam longint ROT_TWO_PI  = 64'sd6746518852;
    localparam longint ROT_HALF_PI = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sh26DD3B6A;
    localparam longint UNIT_Q30    = 64'sh40000000;
    localparam int     PIPE_DEPTH  = 21;
    localparam t_coord ONE_FX      = 32'sh0001_0000;
    localparam t_coord MAX_FX      = 32'sh7FFF_FFFF;
    localparam t_coord MIN_FX      = 32'sh8000_0000;

    typedef logic signed [19:0] t_angle;

    typedef struct {
        t_coord px, py, pz;
        t_coord qx, qy, qz;
        t_angle ang;
        t_axis  axis;
    } t_job;

    typedef struct {
        t_coord rx, ry, rz;
        logic   err;
    } t_rot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    longint arctan_q30 [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    t_rot rotated_q[$];
    int   err_count = 0;
    int   sent_count = 0;
    int   result_count = 0;
    int   bad_axis_count = 0;
    int   in_stall_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;

    rotate_point_about_pivot dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // cos/sin in Q30 via folded rotation-mode cordic
    function automatic void trig_of(input t_angle ang, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z    = longint'(ang) * 16384;
        x    = CORDIC_GAIN;
        y    = 0;
        flip = 1'b0;
        if (z > ROT_PI) begin
            z -= ROT_TWO_PI;
        end else if (z < -ROT_PI) begin
            z += ROT_TWO_PI;
        end
        if (z > ROT_HALF_PI) begin
            z -= ROT_PI;
            flip = 1'b1;
        end else if (z < -ROT_HALF_PI) begin
            z += ROT_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_q30[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_q30[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x > UNIT_Q30) ? UNIT_Q30 : ((x < -UNIT_Q30) ? -UNIT_Q30 : x);
        s = (y > UNIT_Q30) ? UNIT_Q30 : ((y < -UNIT_Q30) ? -UNIT_Q30 : y);
    endfunction

    function automatic t_coord rot_term(input longint c, input longint a, input longint s,
                                        input longint b, input longint piv);
        logic signed [67:0] cw, aw, sw, bw, acc;
        longint r;
        t_coord o;
        cw  = c;
        aw  = a;
        sw  = s;
        bw  = b;
        acc = cw * aw + sw * bw + 68'sd536870912;
        r   = longint'(acc >>> 30) + piv;
        if (r > 64'sd2147483647) begin
            o = MAX_FX;
        end else if (r < -64'sd2147483648) begin
            o = MIN_FX;
        end else begin
            o = t_coord'(r);
        end
        return o;
    endfunction

    function automatic t_rot predict_rotation(input t_job j);
        longint p[3], q[3], d[3];
        longint c, s;
        t_rot   o;
        p[0] = j.px;  p[1] = j.py;  p[2] = j.pz;
        q[0] = j.qx;  q[1] = j.qy;  q[2] = j.qz;
        for (int k = 0; k < 3; k++) begin
            d[k] = p[k] - q[k];
        end
        trig_of(j.ang, c, s);
        o.rx  = j.px;
        o.ry  = j.py;
        o.rz  = j.pz;
        o.err = (j.axis == AX_BAD);
        case (j.axis)
            AX_X: begin
                o.ry = rot_term(c, d[1], -s, d[2], q[1]);
                o.rz = rot_term(s, d[1], c, d[2], q[2]);
            end
            AX_Y: begin
                o.rx = rot_term(c, d[0], s, d[2], q[0]);
                o.rz = rot_term(-s, d[0], c, d[2], q[2]);
            end
            AX_Z: begin
                o.rx = rot_term(c, d[0], -s, d[1], q[0]);
                o.ry = rot_term(s, d[0], c, d[1], q[1]);
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_job make_job(input t_coord px, input t_coord py, input t_coord pz,
                                      input t_coord qx, input t_coord qy, input t_coord qz,
                                      input t_angle ang, input t_axis axis);
        t_job j;
        j.px = px;  j.py = py;  j.pz = pz;
        j.qx = qx;  j.qy = qy;  j.qz = qz;
        j.ang  = ang;
        j.axis = axis;
        return j;
    endfunction

    function automatic t_coord rand_coord(input t_coord near);
        t_coord v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom_range(0, 2**21) - 2**20;
            5:       v = $urandom_range(0, 1) ? MAX_FX : MIN_FX;
            default: v = near + ($urandom_range(0, 2**18) - 2**17);
        endcase
        return v;
    endfunction

    function automatic t_angle rand_angle();
        t_angle a;
        case ($urandom_range(0, 19))
            0, 1: a = t_angle'($urandom);
            2: begin
                case ($urandom_range(0, 5))
                    0:       a = 20'sd102944;
                    1:       a = 20'sd102945;
                    2:       a = 20'sd205887;
                    3:       a = 20'sd205888;
                    4:       a = 20'sd411775;
                    default: a = 20'sd0;
                endcase
                if ($urandom_range(0, 1)) a = -a;
            end
            default: a = t_angle'(int'($urandom_range(0, 823550)) - 411775);
        endcase
        return a;
    endfunction

    // one input transaction, expectation queued on acceptance
    task automatic send_job(input t_job j);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, j.ang, j.qz, j.qy, j.qx, j.pz, j.py, j.px};
        s_axis_tuser  <= j.axis;
        do @(posedge i_clk); while (!s_axis_tready);
        rotated_q.push_back(predict_rotation(j));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        t_job j[$];
        j.push_back(make_job(ONE_FX, 2 * ONE_FX, 3 * ONE_FX, 0, 0, 0, 0, AX_X));
        j.push_back(make_job(ONE_FX, 2 * ONE_FX, 3 * ONE_FX, 0, 0, 0, 0, AX_Y));
        j.push_back(make_job(ONE_FX, 2 * ONE_FX, 3 * ONE_FX, 0, 0, 0, 0, AX_Z));
        j.push_back(make_job(ONE_FX, 0, 0, 0, 0, 0, 20'sd102944, AX_Z));
        j.push_back(make_job(ONE_FX, 0, 0, 0, 0, 0, 20'sd102945, AX_Z));
        j.push_back(make_job(ONE_FX, 0, 0, 0, 0, 0, -20'sd102944, AX_Z));
        j.push_back(make_job(ONE_FX, 0, 0, 0, 0, 0, -20'sd102945, AX_Z));
        j.push_back(make_job(0, ONE_FX, ONE_FX, 0, 0, 0, 20'sd205887, AX_X));
        j.push_back(make_job(0, ONE_FX, ONE_FX, 0, 0, 0, 20'sd205888, AX_X));
        j.push_back(make_job(ONE_FX, 0, ONE_FX, 0, 0, 0, -20'sd205887, AX_Y));
        j.push_back(make_job(ONE_FX, 0, ONE_FX, 0, 0, 0, -20'sd205888, AX_Y));
        j.push_back(make_job(ONE_FX, ONE_FX, 0, 0, 0, 0, 20'sd411775, AX_Z));
        j.push_back(make_job(ONE_FX, ONE_FX, 0, 0, 0, 0, -20'sd411775, AX_Z));
        // patterns outside the stated angle range
        j.push_back(make_job(ONE_FX, ONE_FX, ONE_FX, 0, 0, 0, 20'sh7FFFF, AX_X));
        j.push_back(make_job(ONE_FX, ONE_FX, ONE_FX, 0, 0, 0, 20'sh80000, AX_Y));
        // invalid axis passes the point straight through
        j.push_back(make_job(MAX_FX, MIN_FX, ONE_FX, 5, 6, 7, 20'sd12345, AX_BAD));
        // opposite extremes: saturation both ways
        j.push_back(make_job(MAX_FX, MAX_FX, MAX_FX, MIN_FX, MIN_FX, MIN_FX,
                             20'sd51472, AX_X));
        j.push_back(make_job(MIN_FX, MIN_FX, MIN_FX, MAX_FX, MAX_FX, MAX_FX,
                             20'sd51472, AX_Y));
        j.push_back(make_job(MAX_FX, MIN_FX, MAX_FX, MIN_FX, MAX_FX, MIN_FX,
                             -20'sd154416, AX_Z));
        j.push_back(make_job(MIN_FX, MAX_FX, MIN_FX, MAX_FX, MIN_FX, MAX_FX,
                             20'sd205888, AX_Z));
        // point on the pivot
        j.push_back(make_job(MAX_FX, MIN_FX, MAX_FX, MAX_FX, MIN_FX, MAX_FX,
                             20'sd77777, AX_X));
        j.push_back(make_job(MIN_FX, MAX_FX, -1, MIN_FX, MAX_FX, -1, -20'sd300000, AX_Y));
        foreach (j[i]) send_job(j[i]);
        wait_drained();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
        t_job j;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            j.qx   = rand_coord(0);
            j.qy   = rand_coord(0);
            j.qz   = rand_coord(0);
            j.px   = rand_coord(j.qx);
            j.py   = rand_coord(j.qy);
            j.pz   = rand_coord(j.qz);
            j.ang  = rand_angle();
            j.axis = ($urandom_range(0, 9) == 0) ? AX_BAD : t_axis'($urandom_range(0, 2));
            send_job(j);
        end
        wait_drained();
    endtask

    // receiver holds off long enough for the pipe and skid register to fill
    task automatic test_backpressure();
        t_job j;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        repeat (80) begin
            j = make_job($urandom, $urandom, $urandom,
                         $urandom_range(0, 2**20), 0, -ONE_FX,
                         rand_angle(), t_axis'($urandom_range(0, 3)));
            send_job(j);
        end
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
    end

    always @(posedge i_clk) begin : check_results
        t_rot want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rotated_q.size() == 0) begin
                $error("unexpected result transaction, tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                want = rotated_q.pop_front();
                result_count++;
                if (want.err) bad_axis_count++;
                if (m_axis_tdata[31:0] !== want.rx) begin
                    $error("rotated_x: expected %0d, got %0d",
                           want.rx, $signed(m_axis_tdata[31:0]));
                    err_count++;
                end
                if (m_axis_tdata[63:32] !== want.ry) begin
                    $error("rotated_y: expected %0d, got %0d",
                           want.ry, $signed(m_axis_tdata[63:32]));
                    err_count++;
                end
                if (m_axis_tdata[95:64] !== want.rz) begin
                    $error("rotated_z: expected %0d, got %0d",
                           want.rz, $signed(m_axis_tdata[95:64]));
                    err_count++;
                end
                if (m_axis_tuser[0] !== want.err) begin
                    $error("axis_error: expected %0d, got %0d", want.err, m_axis_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("rotate_point_about_pivot_tb: done, errors");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_phase(370, 0, 0);
        test_random_phase(370, 75, 0);
        test_random_phase(370, 0, 75);
        test_random_phase(370, 35, 35);
        test_backpressure();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        $display("rotate_point_about_pivot_tb: %0d of %0d points rotated about x/y/z, %0d invalid axis",
                 result_count, sent_count, bad_axis_count);
        $display("rotate_point_about_pivot_tb: %0d input stall cycles, %0d mismatches",
                 in_stall_cycles, err_count);
        if (err_count == 0) begin
            $display("rotate_point_about_pivot_tb: done, clean");
        end else begin
            $display("rotate_point_about_pivot_tb: done, errors");
        end
        $finish;
    end

endmodule
